@@ sv/bra_pkg.sv @@
`timescale 1ns / 1ps

package bra_pkg;

   // table geometry
   localparam int NUM_PROCS = 16;
   localparam int NUM_RES   = 16;
   localparam int UNIT_BITS = 4;

   // fixed field widths of the stream payload
   localparam int OP_BITS     = 2;
   localparam int PID_BITS    = 4;
   localparam int RID_BITS    = 4;
   localparam int COUNT_BITS  = 4;
   localparam int STATUS_BITS = 3;
   localparam int MASK_BITS   = 16;

   localparam int PROC_IDX  = $clog2(NUM_PROCS);
   localparam int RES_IDX   = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
   localparam int ADDR_BITS = PROC_IDX + RES_IDX;
   localparam int HELD_BITS = UNIT_BITS + 1;
   localparam int WORK_BITS = UNIT_BITS + PROC_IDX + 2;

   typedef logic [UNIT_BITS-1:0] unit_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [WORK_BITS-1:0] work_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_REQUEST = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLAIM   = 2'd2,
      OP_AVAIL   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_GRANTED        = 3'd0,
      ST_DENIED_UNAVAIL = 3'd1,
      ST_DENIED_UNSAFE  = 3'd2,
      ST_RELEASED       = 3'd3,
      ST_TERMINATED     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_REL_SCAN,
      S_TERM_SCAN,
      S_REQ_CHECK,
      S_SAFE_PICK,
      S_SAFE_ROW,
      S_SAFE_ADV,
      S_GRANT_SCAN,
      S_DONE
   } state_type;

   // one input element
   typedef struct packed {
      op_type                op;
      logic [PID_BITS-1:0]   pid;
      logic [RID_BITS-1:0]   rid;
      logic [COUNT_BITS-1:0] units;
      logic                  last;
   } item_type;

   // table memory commands
   typedef struct packed {
      logic     claim_we;
      addr_type claim_waddr;
      unit_type claim_wdata;
      logic     alloc_we;
      addr_type alloc_waddr;
      unit_type alloc_wdata;
      addr_type raddr;
   } mem_cmd_type;

   // answer toward the output register
   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [PID_BITS-1:0] pid;
   } res_type;

   function automatic logic is_shared(logic [MASK_BITS-1:0] mask, logic [RES_IDX-1:0] r);
      return (32'(r) < MASK_BITS) && mask[4'(r)];
   endfunction

   function automatic unit_type sat_add(unit_type a, unit_type b);
      logic [UNIT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[UNIT_BITS] ? '1 : sum[UNIT_BITS-1:0];
   endfunction

endpackage

@@ sv/bankers_resource_allocator.sv @@
`timescale 1ns / 1ps
// Banker's resource allocator.
// Input stream req_*: one element per transfer (set available count, declare
// a max claim, or stage one element of a request or release vector); tlast
// closes a request or release vector. Result stream rsp_*: one answer per
// closed vector carrying status and process slot. csr_wr_en/csr_wr_data load
// the shared-resource mask.
// A release scans the process's table row, plus a clearing pass over the row
// on termination. A request denied as unavailable ends after the check;
// otherwise the safety walk reads one table row per process, for up to
// NUM_PROCS passes, bounded by the single read port of the claim and
// allocation memories.
// After reset a clearing pass over all NUM_PROCS * NUM_RES table entries
// zeroes both tables; req_tready stays low during it.
// The answer sits in an output register; the next element is taken while it
// waits. A stalled receiver holds the next answer in its final state until
// the register frees.
module bankers_resource_allocator
   import bra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // operation, process_id, resource_id, unit_count
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // status, answered_process
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [MASK_BITS-1:0] shared_ff;
   logic                 rsp_valid_ff;
   status_type           status_ff;
   logic [PID_BITS-1:0]  pid_ff;
   logic                 rsp_free;
   item_type             item;
   mem_cmd_type          cmd;
   res_type              res;
   unit_type             claim_rd, alloc_rd;

   // unpack the input element
   assign item.op    = op_type'(req_tdata[1:0]);
   assign item.pid   = req_tdata[5:2];
   assign item.rid   = req_tdata[9:6];
   assign item.units = req_tdata[13:10];
   assign item.last  = req_tlast;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // shared mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         shared_ff <= '0;
      end else if (csr_wr_en) begin
         shared_ff <= csr_wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         status_ff <= res.status;
         pid_ff    <= res.pid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, pid_ff, status_ff};

   bra_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .item        (item),
      .shared_mask (shared_ff),
      .rsp_free    (rsp_free),
      .claim_rd    (claim_rd),
      .alloc_rd    (alloc_rd),
      .cmd         (cmd),
      .res         (res)
   );

   bra_tables u_tables (
      .clock    (clock),
      .cmd      (cmd),
      .claim_rd (claim_rd),
      .alloc_rd (alloc_rd)
   );

endmodule

@@ sv/bra_tables.sv @@
`timescale 1ns / 1ps

module bra_tables
   import bra_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type cmd,
   output unit_type    claim_rd,
   output unit_type    alloc_rd
);

   unit_type claim_mem [2**ADDR_BITS];
   unit_type alloc_mem [2**ADDR_BITS];

   // max claim table
   always_ff @(posedge clock) begin
      if (cmd.claim_we) begin
         claim_mem[cmd.claim_waddr] <= cmd.claim_wdata;
      end
      claim_rd <= claim_mem[cmd.raddr];
   end

   // allocation table
   always_ff @(posedge clock) begin
      if (cmd.alloc_we) begin
         alloc_mem[cmd.alloc_waddr] <= cmd.alloc_wdata;
      end
      alloc_rd <= alloc_mem[cmd.raddr];
   end

endmodule

@@ sv/bra_ctrl.sv @@
`timescale 1ns / 1ps

module bra_ctrl
   import bra_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  item_type             item,
   input  logic [MASK_BITS-1:0] shared_mask,
   input  logic                 rsp_free,
   input  unit_type             claim_rd,
   input  unit_type             alloc_rd,
   output mem_cmd_type          cmd,
   output res_type              res
);

   state_type               state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_ff;
   logic [RES_IDX:0]        cnt_ff;
   logic                    dv_ff;
   logic [RES_IDX-1:0]      dr_ff;
   logic [PROC_IDX-1:0]     pid_ff;
   logic [PROC_IDX-1:0]     row_ff;
   logic                    term_ff;
   logic                    fits_ff;
   logic                    progress_ff;
   status_type              status_ff;
   unit_type                avail_ff  [NUM_RES];
   unit_type                staged_ff [NUM_RES];
   work_type                work_ff   [NUM_RES];
   work_type                tmp_ff    [NUM_RES];
   logic [NUM_PROCS-1:0]    finish_ff;

   logic                    rid_ok, pid_ok, issue, row_end, sh, unavail;
   logic                    term_now, fits_r, progress_now;
   logic [NUM_PROCS-1:0]    fin_now;
   logic [PROC_IDX-1:0]     row_sel;
   logic [RES_IDX-1:0]      rid_idx;
   unit_type                units, amt, stg;
   logic [HELD_BITS-1:0]    held;
   work_type                work_r;

   assign rid_ok  = 32'(item.rid) < NUM_RES;
   assign pid_ok  = 32'(item.pid) < NUM_PROCS;
   assign rid_idx = RES_IDX'(item.rid);
   assign units   = unit_type'(item.units);

   // data stage of a row scan
   assign sh       = is_shared(shared_mask, dr_ff);
   assign stg      = staged_ff[dr_ff];
   assign work_r   = work_ff[dr_ff];
   assign amt      = (stg < alloc_rd) ? stg : alloc_rd;
   assign row_end  = dv_ff && (dr_ff == RES_IDX'(NUM_RES - 1));
   assign term_now = term_ff && (claim_rd == '0);
   assign held     = HELD_BITS'(alloc_rd) + ((row_ff == pid_ff) ? HELD_BITS'(stg) : '0);
   assign fits_r   = sh || ((WORK_BITS+1)'(claim_rd) <=
                            (WORK_BITS+1)'(held) + (WORK_BITS+1)'(work_r));

   // end of one process row in the safety walk
   always_comb begin
      fin_now = finish_ff;
      if (fits_ff) begin
         fin_now[row_ff] = 1'b1;
      end
      progress_now = progress_ff || fits_ff;
   end

   // any non-shared element beyond the available count
   always_comb begin
      unavail = 1'b0;
      for (int r = 0; r < NUM_RES; r++) begin
         if (!is_shared(shared_mask, RES_IDX'(r)) && (staged_ff[r] > avail_ff[r])) begin
            unavail = 1'b1;
         end
      end
   end

   assign issue = ((state_ff == S_REL_SCAN) || (state_ff == S_SAFE_ROW) ||
                   (state_ff == S_GRANT_SCAN) || (state_ff == S_TERM_SCAN)) &&
                  (32'(cnt_ff) < NUM_RES);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, memory commands, handshake
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      res        = '0;
      row_sel    = ((state_ff == S_REL_SCAN) || (state_ff == S_GRANT_SCAN)) ? pid_ff : row_ff;
      cmd.raddr  = {row_sel, cnt_ff[RES_IDX-1:0]};
      case (state_ff)
         S_CLEAR: begin
            cmd.claim_we    = 1'b1;
            cmd.claim_waddr = clr_ff;
            cmd.alloc_we    = 1'b1;
            cmd.alloc_waddr = clr_ff;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (item.op)
                  OP_CLAIM: begin
                     if (rid_ok && pid_ok) begin
                        cmd.claim_we    = 1'b1;
                        cmd.claim_waddr = {PROC_IDX'(item.pid), rid_idx};
                        cmd.claim_wdata = units;
                     end
                  end
                  OP_AVAIL: begin
                  end
                  default: begin
                     if (item.last && pid_ok) begin
                        state_in = (item.op == OP_RELEASE) ? S_REL_SCAN : S_REQ_CHECK;
                     end
                  end
               endcase
            end
         end
         S_REL_SCAN: begin
            if (dv_ff && !sh) begin
               cmd.alloc_we    = 1'b1;
               cmd.alloc_waddr = {pid_ff, dr_ff};
               cmd.alloc_wdata = alloc_rd - amt;
            end
            if (row_end) begin
               state_in = term_now ? S_TERM_SCAN : S_DONE;
            end
         end
         S_TERM_SCAN: begin
            cmd.alloc_we    = 1'b1;
            cmd.alloc_waddr = {pid_ff, cnt_ff[RES_IDX-1:0]};
            if (32'(cnt_ff) == NUM_RES - 1) begin
               state_in = S_DONE;
            end
         end
         S_REQ_CHECK: begin
            state_in = unavail ? S_DONE : S_SAFE_PICK;
         end
         S_SAFE_PICK: begin
            state_in = finish_ff[row_ff] ? S_SAFE_ADV : S_SAFE_ROW;
         end
         S_SAFE_ROW: begin
            if (row_end) begin
               state_in = S_SAFE_ADV;
            end
         end
         S_SAFE_ADV: begin
            if (&fin_now) begin
               state_in = S_GRANT_SCAN;
            end else if ((32'(row_ff) == NUM_PROCS - 1) && !progress_now) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SAFE_PICK;
            end
         end
         S_GRANT_SCAN: begin
            if (dv_ff && !sh) begin
               cmd.alloc_we    = 1'b1;
               cmd.alloc_waddr = {pid_ff, dr_ff};
               cmd.alloc_wdata = sat_add(alloc_rd, stg);
            end
            if (row_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               res.valid  = 1'b1;
               res.status = status_ff;
               res.pid    = PID_BITS'(pid_ff);
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer counters and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         cnt_ff      <= '0;
         dv_ff       <= 1'b0;
         finish_ff   <= '0;
         progress_ff <= 1'b0;
         fits_ff     <= 1'b0;
         for (int r = 0; r < NUM_RES; r++) begin
            avail_ff[r]  <= '0;
            staged_ff[r] <= '0;
         end
      end else begin
         // row read pipeline
         if (state_in != state_ff) begin
            cnt_ff <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         dv_ff <= issue && (state_ff != S_TERM_SCAN) && (state_in == state_ff);
         dr_ff <= cnt_ff[RES_IDX-1:0];

         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  case (item.op)
                     OP_AVAIL: begin
                        if (rid_ok) begin
                           avail_ff[rid_idx] <= units;
                        end
                     end
                     OP_CLAIM: begin
                     end
                     default: begin
                        if (pid_ok && rid_ok) begin
                           staged_ff[rid_idx] <= units;
                        end
                        if (item.last && !pid_ok) begin
                           for (int r = 0; r < NUM_RES; r++) begin
                              staged_ff[r] <= '0;
                           end
                        end
                        pid_ff  <= PROC_IDX'(item.pid);
                        term_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_REL_SCAN: begin
               if (dv_ff) begin
                  if (!sh) begin
                     avail_ff[dr_ff] <= sat_add(avail_ff[dr_ff], amt);
                  end
                  term_ff <= term_now;
               end
               if (row_end) begin
                  status_ff <= term_now ? ST_TERMINATED : ST_RELEASED;
               end
            end
            S_TERM_SCAN: begin
            end
            S_REQ_CHECK: begin
               status_ff   <= ST_DENIED_UNAVAIL;
               finish_ff   <= '0;
               row_ff      <= '0;
               progress_ff <= 1'b0;
               for (int r = 0; r < NUM_RES; r++) begin
                  work_ff[r] <= WORK_BITS'(avail_ff[r]) - WORK_BITS'(staged_ff[r]);
               end
            end
            S_SAFE_PICK: begin
               fits_ff <= !finish_ff[row_ff];
            end
            S_SAFE_ROW: begin
               if (dv_ff) begin
                  fits_ff       <= fits_ff && fits_r;
                  tmp_ff[dr_ff] <= sh ? work_r : work_r + WORK_BITS'(held);
               end
            end
            S_SAFE_ADV: begin
               status_ff <= ST_DENIED_UNSAFE;
               finish_ff <= fin_now;
               if (fits_ff) begin
                  for (int r = 0; r < NUM_RES; r++) begin
                     work_ff[r] <= tmp_ff[r];
                  end
               end
               // a new pass starts after the last process
               if (32'(row_ff) == NUM_PROCS - 1) begin
                  row_ff      <= '0;
                  progress_ff <= 1'b0;
               end else begin
                  row_ff      <= row_ff + 1'b1;
                  progress_ff <= progress_now;
               end
            end
            S_GRANT_SCAN: begin
               status_ff <= ST_GRANTED;
               if (dv_ff && !sh) begin
                  avail_ff[dr_ff] <= avail_ff[dr_ff] - stg;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  for (int r = 0; r < NUM_RES; r++) begin
                     staged_ff[r] <= '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // a finished process is never walked again within one check
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SAFE_ROW) |-> !finish_ff[row_ff])
      else $error("finished process rescanned");

   // a release never raises an allocation
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_REL_SCAN) && cmd.alloc_we) |-> (cmd.alloc_wdata <= alloc_rd))
      else $error("release raised allocation");

   // a grant is only written after the safety walk
   assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_GRANT_SCAN) |-> ($past(state_ff) == S_SAFE_ADV))
      else $error("grant without safety check");

   // no input transfer outside the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_IDLE))
      else $error("input transfer outside idle");

endmodule

@@ tb/sv/bankers_resource_allocator_checker.sv @@
`timescale 1ns / 1ps

module bankers_resource_allocator_checker
   import bra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // operation, process_id, resource_id, unit_count
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // status, answered_process
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          answers_pending
);

   typedef struct {
      status_type          status;
      logic [PID_BITS-1:0] pid;
   } answer_type;

   // predicted block state
   logic [UNIT_BITS-1:0] held_units [NUM_PROCS][NUM_RES];
   logic [UNIT_BITS-1:0] max_claim  [NUM_PROCS][NUM_RES];
   logic [UNIT_BITS-1:0] free_units [NUM_RES];
   logic [UNIT_BITS-1:0] vector_buf [NUM_RES];
   logic [MASK_BITS-1:0] shared_res;

   answer_type expected_answers [$];

   function automatic bit res_shared(int r);
      return r < 16 && shared_res[r];
   endfunction

   // banker's walk on the state as if the staged vector were granted to pid
   function automatic bit grant_keeps_safe(int pid);
      int work [NUM_RES];
      int held [NUM_PROCS][NUM_RES];
      bit finished [NUM_PROCS];
      bit progress;
      bit fits;
      for (int r = 0; r < NUM_RES; r++) begin
         work[r] = int'(free_units[r]) - int'(vector_buf[r]);
      end
      for (int i = 0; i < NUM_PROCS; i++) begin
         finished[i] = 0;
         for (int r = 0; r < NUM_RES; r++) begin
            held[i][r] = int'(held_units[i][r]) + ((i == pid) ? int'(vector_buf[r]) : 0);
         end
      end
      for (int pass = 0; pass < NUM_PROCS; pass++) begin
         progress = 0;
         for (int i = 0; i < NUM_PROCS; i++) begin
            if (!finished[i]) begin
               fits = 1;
               for (int r = 0; r < NUM_RES; r++) begin
                  if (!res_shared(r) && int'(max_claim[i][r]) - held[i][r] > work[r]) begin
                     fits = 0;
                  end
               end
               if (fits) begin
                  for (int r = 0; r < NUM_RES; r++) begin
                     if (!res_shared(r)) work[r] += held[i][r];
                  end
                  finished[i] = 1;
                  progress = 1;
               end
            end
         end
         if (!progress) break;
      end
      for (int i = 0; i < NUM_PROCS; i++) begin
         if (!finished[i]) return 0;
      end
      return 1;
   endfunction

   // apply one accepted element, queue the answer if it closes a vector
   function automatic void apply_element(op_type op, int pid, int rid, logic [3:0] units,
                                         bit last);
      answer_type ans;
      bit unavailable;
      bit terminate;
      logic [UNIT_BITS-1:0] amt;
      if (op == OP_CLAIM) begin
         max_claim[pid][rid] = units;
         return;
      end
      if (op == OP_AVAIL) begin
         free_units[rid] = units;
         return;
      end
      vector_buf[rid] = units;
      if (!last) return;
      if (op == OP_RELEASE) begin
         terminate = 1;
         for (int r = 0; r < NUM_RES; r++) begin
            if (!res_shared(r)) begin
               amt = (vector_buf[r] < held_units[pid][r]) ? vector_buf[r] : held_units[pid][r];
               held_units[pid][r] -= amt;
               free_units[r] = (int'(free_units[r]) + int'(amt) > 15) ? 4'hF
                                                                     : free_units[r] + amt;
            end
            if (max_claim[pid][r] != 0) terminate = 0;
         end
         if (terminate) begin
            for (int r = 0; r < NUM_RES; r++) held_units[pid][r] = '0;
            ans.status = ST_TERMINATED;
         end else begin
            ans.status = ST_RELEASED;
         end
      end else begin
         unavailable = 0;
         for (int r = 0; r < NUM_RES; r++) begin
            if (!res_shared(r) && vector_buf[r] > free_units[r]) unavailable = 1;
         end
         if (unavailable) begin
            ans.status = ST_DENIED_UNAVAIL;
         end else if (!grant_keeps_safe(pid)) begin
            ans.status = ST_DENIED_UNSAFE;
         end else begin
            for (int r = 0; r < NUM_RES; r++) begin
               if (!res_shared(r)) begin
                  free_units[r] -= vector_buf[r];
                  held_units[pid][r] = (int'(held_units[pid][r]) + int'(vector_buf[r]) > 15)
                                       ? 4'hF : held_units[pid][r] + vector_buf[r];
               end
            end
            ans.status = ST_GRANTED;
         end
      end
      for (int r = 0; r < NUM_RES; r++) vector_buf[r] = '0;
      ans.pid = pid[PID_BITS-1:0];
      expected_answers.push_back(ans);
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      answer_type exp_ans;
      if (reset) begin
         fail_count <= 0;
         shared_res = '0;
         expected_answers.delete();
         for (int i = 0; i < NUM_PROCS; i++) begin
            for (int r = 0; r < NUM_RES; r++) begin
               held_units[i][r] = '0;
               max_claim[i][r] = '0;
            end
         end
         for (int r = 0; r < NUM_RES; r++) begin
            free_units[r] = '0;
            vector_buf[r] = '0;
         end
      end else begin
         if (csr_wr_en) shared_res = csr_wr_data;
         if (req_tvalid && req_tready) begin
            apply_element(op_type'(req_tdata[1:0]), int'(req_tdata[5:2]), int'(req_tdata[9:6]),
                          req_tdata[13:10], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               if (fail_count < 10) $display("unexpected answer: tdata %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_ans = expected_answers.pop_front();
               if (rsp_tdata[2:0] != exp_ans.status || rsp_tdata[6:3] != exp_ans.pid
                   || rsp_tdata[7] != 1'b0) begin
                  if (fail_count < 10) begin
                     $display("answer mismatch: expected status %0d pid %0d, got status %0d pid %0d",
                              exp_ans.status, exp_ans.pid, rsp_tdata[2:0], rsp_tdata[6:3]);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      answers_pending <= expected_answers.size();
   end

endmodule

@@ tb/sv/bankers_resource_allocator_tb.sv @@
`timescale 1ns / 1ps

module bankers_resource_allocator_tb;
   import bra_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // operation, process_id, resource_id, unit_count
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // status, answered_process
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   int fail_count;
   int answers_pending;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_request;
   bit hold_taken;
   int hold_left;
   int cycle_count;
   int items_sent;

   bankers_resource_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bankers_resource_allocator_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .answers_pending (answers_pending)
   );

   // clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result receiver with random stalls and one long hold-off
   initial begin
      rsp_tready = 0;
      hold_left = 0;
      hold_taken = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken && hold_left == 0) begin
            hold_left = 3000;
            hold_taken = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // one element transfer; returns after the accepting edge
   task automatic send_element(op_type op, int pid, int rid, int units, bit last);
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, 4'(units), 4'(rid), 4'(pid), op};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // drain all answers, then write the shared mask while idle
   task automatic write_shared_mask(logic [15:0] mask);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mask;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // a vector of n elements for one process, small counts mostly
   task automatic send_vector(op_type op, int pid, int n);
      int rid;
      for (int k = 0; k < n; k++) begin
         rid = $urandom_range(15);
         send_element(op, pid, rid,
                      ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3),
                      k == n - 1);
      end
   endtask

   // one random piece of traffic: mostly well-formed, some noise
   task automatic send_random_traffic();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         send_element(OP_AVAIL, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                      $urandom_range(1));
      end else if (pick < 35) begin
         send_element(OP_CLAIM, $urandom_range(15), $urandom_range(15),
                      ($urandom_range(3) == 0) ? 0 : $urandom_range(15), $urandom_range(1));
      end else if (pick < 65) begin
         send_vector(OP_REQUEST, $urandom_range(15), $urandom_range(1, 4));
      end else if (pick < 85) begin
         send_vector(OP_RELEASE, $urandom_range(15), $urandom_range(1, 4));
      end else begin
         send_element(op_type'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                      $urandom_range(15), $urandom_range(1));
      end
   endtask

   // stimulus and verdict
   initial begin
      reset          = 1;
      req_tvalid     = 0;
      req_tdata      = '0;
      req_tlast      = 0;
      csr_wr_en      = 0;
      csr_wr_data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 0;
      items_sent     = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      write_shared_mask(16'h0000);

      // directed: fill availability, claims, then the special cases
      send_element(OP_AVAIL, 0, 0, 15, 0);
      send_element(OP_AVAIL, 0, 1, 4, 1);          // last on an available write
      send_element(OP_AVAIL, 0, 15, 2, 0);
      send_element(OP_CLAIM, 1, 0, 15, 0);
      send_element(OP_CLAIM, 1, 1, 4, 1);          // last on a claim
      send_element(OP_CLAIM, 2, 1, 4, 0);
      send_element(OP_REQUEST, 1, 0, 5, 0);
      send_element(OP_REQUEST, 1, 1, 2, 1);        // granted
      send_element(OP_REQUEST, 2, 1, 3, 1);        // unavailable
      send_element(OP_REQUEST, 2, 15, 3, 1);       // unavailable
      send_element(OP_REQUEST, 3, 0, 1, 1);        // beyond claim
      send_element(OP_RELEASE, 1, 0, 15, 1);       // clipped release
      send_element(OP_REQUEST, 4, 1, 1, 0);        // staged under another process
      send_element(OP_RELEASE, 3, 0, 1, 1);        // terminates
      send_element(OP_RELEASE, 15, 15, 0, 1);
      send_element(OP_AVAIL, 15, 5, 15, 0);
      send_element(OP_REQUEST, 15, 5, 15, 1);
      send_element(OP_RELEASE, 15, 5, 15, 1);
      send_element(OP_RELEASE, 1, 1, 15, 1);

      // shared everything, random masks, nothing shared, random low byte; each its own idle mix
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_shared_mask(16'hFFFF);
            1: write_shared_mask(16'($urandom));
            2: write_shared_mask(16'($urandom));
            3: write_shared_mask(16'h0000);
            default: write_shared_mask(16'($urandom) & 16'h00FF);
         endcase
         send_idle_pct  = (phase == 1 || phase == 3) ? 56 : (phase == 4 ? 38 : 0);
         recv_stall_pct = (phase == 2 || phase == 3) ? 56 : (phase == 4 ? 38 : 0);
         if (phase == 0) hold_request = 1;
         while (items_sent < 19 + 190 * (phase + 1)) send_random_traffic();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bra_pkg.sv
sv/bra_tables.sv
sv/bra_ctrl.sv
sv/bankers_resource_allocator.sv
tb/sv/bankers_resource_allocator_checker.sv
tb/sv/bankers_resource_allocator_tb.sv
